/* rtl/core/tile_cache_farthest_eviction_top_macros.svh */
// ----------------------------------------------------------------------------
// Tile cache assertion macros
// Shared concurrent assertion forms for the tile cache checkers.
// ----------------------------------------------------------------------------
`ifndef TILE_CACHE_FARTHEST_EVICTION_TOP_MACROS_SVH
`define TILE_CACHE_FARTHEST_EVICTION_TOP_MACROS_SVH

// Property checked at the rising clock edge, ignored while reset is low.
`define TCFE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, with the block's own clock and reset names.
`define TCFE_ASSERT_CLK(lbl, prop, msg) `TCFE_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/tcfe_pkg.sv */
// ----------------------------------------------------------------------------
// Tile cache package
// Types and constants shared by the tile cache modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfe_pkg;

  localparam int KEY_W  = 23;
  localparam int SLOT_W = 4;
  localparam int FUNC_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FREE   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/tile_cache_farthest_eviction_top.sv */
// Lookup and insert give their result after the scan, the p1 to p3 pipeline and
// the commit state; free and no-op requests give it on the next cycle.
// A lookup or insert keeps the block busy while the scan reads one entry per cycle
// and each entry passes the p1, p2 and p3 pipeline registers, until the commit
// state; requests are taken only while idle, and free and no-op keep it idle.
// Reset clears the valid marks and control state; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Tile cache top level
// Fully associative tile table, filling the first free slot or else replacing the
// farthest entry, in synchronous key and centre memories scanned entry by entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_cache_farthest_eviction_top #(
  parameter int SLOTS      = 16,
  parameter int COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [tcfe_pkg::FUNC_W-1:0]   func_i,
  input  wire logic signed [8:0]             tile_lon_i,
  input  wire logic signed [7:0]             tile_lat_i,
  input  wire logic [2:0]                    tile_x_i,
  input  wire logic [2:0]                    tile_y_i,
  input  wire logic signed [COORD_BITS-1:0]  center_x_i,
  input  wire logic signed [COORD_BITS-1:0]  center_y_i,
  input  wire logic signed [COORD_BITS-1:0]  center_z_i,
  input  wire logic signed [COORD_BITS-1:0]  view_x_i,
  input  wire logic signed [COORD_BITS-1:0]  view_y_i,
  input  wire logic signed [COORD_BITS-1:0]  view_z_i,
  input  wire logic [tcfe_pkg::SLOT_W-1:0]   slot_in_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic [tcfe_pkg::SLOT_W-1:0]        slot_o,
  output logic                               evicted_o
);

  import tcfe_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = 3 * COORD_BITS;
  localparam int DW = COORD_BITS + 2;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_e state_q, state_d;

  // Request held for the duration of a scan.
  func_e             func_q;
  logic [KEY_W-1:0]  key_q;
  logic [PW-1:0]     ctr_q;
  logic [PW-1:0]     view_q;

  logic [SLOTS-1:0]  valid_q, valid_d;

  logic [KEY_W-1:0]  key_mem [SLOTS];
  logic [PW-1:0]     pt_mem  [SLOTS];
  logic [KEY_W-1:0]  rd_key_q;
  logic [PW-1:0]     rd_pt_q;

  logic [IW-1:0]     scan_idx_q;
  logic              issue_done_q;
  logic              p1_go_q, p2_go_q, p3_go_q;
  logic              p1_last_q, p2_last_q, p3_last_q;
  logic [IW-1:0]     p1_idx_q, p2_idx_q, p3_idx_q;

  logic              found_q, free_found_q;
  logic [IW-1:0]     found_idx_q, free_idx_q, best_idx_q;
  logic [DW-1:0]     best_q;
  logic [DW-1:0]     dist_val;

  logic              done_q, hit_q, evicted_q;
  logic [SLOT_W-1:0] slot_q;

  logic              accept;
  logic              scan_start;
  logic              issue;
  logic              commit;
  logic              free_req;
  logic [IW-1:0]     pick_idx;
  logic              mem_we;

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] idx);
    logic [IW+SLOT_W-1:0] ext;
    ext = (IW + SLOT_W)'(idx);
    return ext[SLOT_W-1:0];
  endfunction

  assign accept     = start && (state_q == ST_IDLE);
  assign scan_start = accept && ((func_e'(func_i) == FUNC_LOOKUP) ||
                                 (func_e'(func_i) == FUNC_INSERT));
  assign free_req   = accept && (func_e'(func_i) == FUNC_FREE) &&
                      (32'(slot_in_i) < SLOTS);
  assign pick_idx   = free_found_q ? free_idx_q : best_idx_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (scan_start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (p3_go_q && p3_last_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    issue  = 1'b0;
    commit = 1'b0;
    busy   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        issue = !issue_done_q;
      end
      ST_FINISH: begin
        commit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign mem_we = commit && (func_q == FUNC_INSERT);

  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_req && (32'(slot_in_i) == i)) begin
        valid_d[i] = 1'b0;
      end
      if (mem_we && (32'(pick_idx) == i)) begin
        valid_d[i] = 1'b1;
      end
    end
  end

  // Table memories: one write port used at commit, one registered read port
  // used by the scan. The two never overlap in time.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[pick_idx] <= key_q;
      pt_mem[pick_idx]  <= ctr_q;
    end
    if (issue) begin
      rd_key_q <= key_mem[scan_idx_q];
      rd_pt_q  <= pt_mem[scan_idx_q];
    end
  end

  tcfe_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .ctr_i  (rd_pt_q),
    .view_i (view_q),
    .dist_o (dist_val)
  );

  // Request capture and slot indexes along the scan pipeline.
  always_ff @(posedge clk_i) begin
    if (scan_start) begin
      func_q <= func_e'(func_i);
      key_q  <= {tile_lon_i, tile_lat_i, tile_x_i, tile_y_i};
      ctr_q  <= {center_x_i, center_y_i, center_z_i};
      view_q <= {view_x_i, view_y_i, view_z_i};
    end
    p1_idx_q <= scan_idx_q;
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      scan_idx_q   <= '0;
      issue_done_q <= 1'b0;
      p1_go_q      <= 1'b0;
      p2_go_q      <= 1'b0;
      p3_go_q      <= 1'b0;
      p1_last_q    <= 1'b0;
      p2_last_q    <= 1'b0;
      p3_last_q    <= 1'b0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      best_q       <= '0;
      best_idx_q   <= '0;
      done_q       <= 1'b0;
      hit_q        <= 1'b0;
      slot_q       <= '0;
      evicted_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      p1_go_q   <= issue;
      p1_last_q <= issue && (scan_idx_q == LAST_IDX);
      p2_go_q   <= p1_go_q;
      p2_last_q <= p1_last_q;
      p3_go_q   <= p2_go_q;
      p3_last_q <= p2_last_q;

      if (scan_start) begin
        scan_idx_q   <= '0;
        issue_done_q <= 1'b0;
        found_q      <= 1'b0;
        found_idx_q  <= '0;
        free_found_q <= 1'b0;
        free_idx_q   <= '0;
        best_q       <= '0;
        best_idx_q   <= '0;
      end else begin
        if (issue) begin
          scan_idx_q <= scan_idx_q + 1'b1;
          if (scan_idx_q == LAST_IDX) begin
            issue_done_q <= 1'b1;
          end
        end
        // The first valid match and the first free slot are kept.
        if (p1_go_q) begin
          if (valid_q[p1_idx_q] && (rd_key_q == key_q) && !found_q) begin
            found_q     <= 1'b1;
            found_idx_q <= p1_idx_q;
          end
          if (!valid_q[p1_idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= p1_idx_q;
          end
        end
        // Strict greater-than keeps the first of equal distances.
        if (p3_go_q && (dist_val > best_q)) begin
          best_q     <= dist_val;
          best_idx_q <= p3_idx_q;
        end
      end

      done_q <= 1'b0;
      if (commit) begin
        done_q <= 1'b1;
        if (func_q == FUNC_INSERT) begin
          hit_q     <= 1'b0;
          slot_q    <= to_slot(pick_idx);
          evicted_q <= !free_found_q;
        end else begin
          hit_q     <= found_q;
          slot_q    <= to_slot(found_idx_q);
          evicted_q <= 1'b0;
        end
      end else if (accept && !scan_start) begin
        done_q    <= 1'b1;
        hit_q     <= 1'b0;
        evicted_q <= 1'b0;
        slot_q    <= (func_e'(func_i) == FUNC_FREE) ? slot_in_i : '0;
      end
    end
  end

  assign done_o    = done_q;
  assign hit_o     = hit_q;
  assign slot_o    = slot_q;
  assign evicted_o = evicted_q;

endmodule

`default_nettype wire

/* rtl/core/tcfe_dist.sv */
// ----------------------------------------------------------------------------
// Tile cache distance unit
// Two-stage pipeline computing max + (med + min) / 4 of the absolute axis
// differences between a stored centre and the view point.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfe_dist #(
  parameter int COORD_BITS = 24
) (
  input  wire logic                      clk_i,
  input  wire logic [3*COORD_BITS-1:0]   ctr_i,
  input  wire logic [3*COORD_BITS-1:0]   view_i,
  output logic      [COORD_BITS+1:0]     dist_o
);

  localparam int CB = COORD_BITS;
  localparam int AW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + 2;

  logic [AW-1:0] abs_d [3];
  logic [AW-1:0] abs_q [3];
  logic [AW-1:0] hi, md, lo, tmp;
  logic [DW-1:0] side_sum;
  logic [DW-1:0] dist_d;

  // Stage A: exact absolute differences, one bit wider than a coordinate.
  always_comb begin
    logic signed [AW-1:0] c_ext;
    logic signed [AW-1:0] v_ext;
    logic signed [AW-1:0] diff;
    for (int a = 0; a < 3; a++) begin
      c_ext = $signed({ctr_i[(3-a)*CB-1], ctr_i[(3-a)*CB-1 -: CB]});
      v_ext = $signed({view_i[(3-a)*CB-1], view_i[(3-a)*CB-1 -: CB]});
      diff  = c_ext - v_ext;
      abs_d[a] = diff[AW-1] ? AW'(-diff) : AW'(diff);
    end
  end

  always_ff @(posedge clk_i) begin
    abs_q <= abs_d;
  end

  // Stage B: bring the largest axis to the front, then add a quarter of the rest.
  always_comb begin
    tmp = '0;
    hi  = abs_q[0];
    md  = abs_q[1];
    lo  = abs_q[2];
    if (hi < md) begin
      tmp = hi;
      hi  = md;
      md  = tmp;
    end
    if (hi < lo) begin
      tmp = hi;
      hi  = lo;
      lo  = tmp;
    end
    side_sum = {1'b0, md} + {1'b0, lo};
    dist_d   = {1'b0, hi} + {2'b00, side_sum[DW-1:2]};
  end

  always_ff @(posedge clk_i) begin
    dist_o <= dist_d;
  end

endmodule

`default_nettype wire

/* rtl/core/tcfe_checker.sv */
// ----------------------------------------------------------------------------
// Tile cache port checker
// Watches the top-level request and result ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_cache_farthest_eviction_top_macros.svh"

module tcfe_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [tcfe_pkg::FUNC_W-1:0]  func_i,
  input wire logic [tcfe_pkg::SLOT_W-1:0]  slot_in_i,
  input wire logic                         done_o,
  input wire logic                         hit_o,
  input wire logic [tcfe_pkg::SLOT_W-1:0]  slot_o,
  input wire logic                         evicted_o
);

  import tcfe_pkg::*;

  logic take_req;
  logic scan_req;
  logic quick_req;
  logic free_take;

  assign take_req  = start && !busy;
  assign scan_req  = take_req && ((func_i == FUNC_LOOKUP) || (func_i == FUNC_INSERT));
  assign quick_req = take_req && ((func_i == FUNC_FREE) || (func_i == FUNC_NOP));
  assign free_take = take_req && (func_i == FUNC_FREE);

  // A result is only ever shown while no scan is running.
  `TCFE_ASSERT_CLK(a_done_not_busy, !(done_o && busy), "result shown while busy")

  // A lookup or insert request starts a scan.
  `TCFE_ASSERT_CLK(a_scan_starts, scan_req |=> busy, "scan did not start")

  // Free and no-op requests answer on the next cycle with no hit and no eviction.
  `TCFE_ASSERT_CLK(a_quick_result, quick_req |=> (done_o && !hit_o && !evicted_o), "quick result missing")

  // A free reports the slot it was given.
  `TCFE_ASSERT_CLK(a_free_slot, free_take |=> (slot_o == $past(slot_in_i)), "free slot mismatch")

  // The end of a scan always delivers its result.
  `TCFE_ASSERT_CLK(a_scan_result, $fell(busy) |-> done_o, "scan ended without result")

endmodule

bind tile_cache_farthest_eviction_top tcfe_checker u_tcfe_checker (.*);

`default_nettype wire

/* tb/tile_cache_farthest_eviction_top_tb.sv */
// ----------------------------------------------------------------------------
// Tile cache testbench
// Drives lookup, insert, free and no-op requests into the tile cache, keeps
// its own copy of the table with farthest-entry replacement, and checks every
// result strobe against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_cache_farthest_eviction_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcfe_pkg::*;

  localparam int SLOTS      = 16;
  localparam int COORD_BITS = 24;
  localparam int RANDOM_REQS = 1700;
  localparam int PHASE_LEN   = 425;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 24'sh800000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    func_e             func;
    logic signed [8:0] lon;
    logic signed [7:0] lat;
    logic [2:0]        tx;
    logic [2:0]        ty;
    coord_t            cx, cy, cz;
    coord_t            vx, vy, vz;
    logic [SLOT_W-1:0] slot;
    int unsigned       idle_pct;
    bit                drain_first;
  } tile_req_t;

  typedef struct {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
  } tile_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic done_o;
  logic hit_o;
  logic [SLOT_W-1:0] slot_o;
  logic evicted_o;

  tile_req_t cur_req = '{func: FUNC_NOP, lon: '0, lat: '0, tx: '0, ty: '0,
                         cx: '0, cy: '0, cz: '0, vx: '0, vy: '0, vz: '0,
                         slot: '0, idle_pct: 0, drain_first: 1'b0};

  tile_req_t    pending_reqs[$];
  tile_result_t expected_results[$];
  int unsigned  accepted_reqs = 0;
  int unsigned  launched_reqs = 0;
  int unsigned  mismatch_count = 0;

  // Shadow of the tile table.
  logic              tbl_valid [SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0]  tbl_key   [SLOTS];
  coord_t            tbl_cx    [SLOTS];
  coord_t            tbl_cy    [SLOTS];
  coord_t            tbl_cz    [SLOTS];

  always #5 clk_i = ~clk_i;

  tile_cache_farthest_eviction_top #(
    .SLOTS      (SLOTS),
    .COORD_BITS (COORD_BITS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (cur_req.func),
    .tile_lon_i (cur_req.lon),
    .tile_lat_i (cur_req.lat),
    .tile_x_i   (cur_req.tx),
    .tile_y_i   (cur_req.ty),
    .center_x_i (cur_req.cx),
    .center_y_i (cur_req.cy),
    .center_z_i (cur_req.cz),
    .view_x_i   (cur_req.vx),
    .view_y_i   (cur_req.vy),
    .view_z_i   (cur_req.vz),
    .slot_in_i  (cur_req.slot),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .slot_o     (slot_o),
    .evicted_o  (evicted_o)
  );

  function automatic longint unsigned axis_gap(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  // Applies one request to the shadow table and returns the result it gives.
  function automatic tile_result_t apply_tile_request(tile_req_t r);
    tile_result_t      res;
    logic [KEY_W-1:0]  key;
    longint unsigned   gx, gy, gz, top, cand_gap, far_dist;
    int                pick;
    res = '{hit: 1'b0, slot: '0, evicted: 1'b0};
    key = {r.lon, r.lat, r.tx, r.ty};
    case (r.func)
      FUNC_LOOKUP: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (tbl_valid[i] && tbl_key[i] == key) begin
            res.hit  = 1'b1;
            res.slot = SLOT_W'(i);
          end
        end
      end
      FUNC_INSERT: begin
        pick = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) pick = i;
        end
        if (pick < 0) begin
          // Table full: the first entry at the largest distance goes.
          pick = 0;
          far_dist = 0;
          for (int i = 0; i < SLOTS; i++) begin
            gx = axis_gap(tbl_cx[i], r.vx);
            gy = axis_gap(tbl_cy[i], r.vy);
            gz = axis_gap(tbl_cz[i], r.vz);
            top = gx;
            if (gy > top) top = gy;
            if (gz > top) top = gz;
            cand_gap = top + (gx + gy + gz - top) / 4;
            if (cand_gap > far_dist) begin
              far_dist = cand_gap;
              pick = i;
            end
          end
          res.evicted = 1'b1;
        end
        tbl_valid[pick] = 1'b1;
        tbl_key[pick]   = key;
        tbl_cx[pick]    = r.cx;
        tbl_cy[pick]    = r.cy;
        tbl_cz[pick]    = r.cz;
        res.slot = SLOT_W'(pick);
      end
      FUNC_FREE: begin
        if (int'(r.slot) < SLOTS) tbl_valid[r.slot] = 1'b0;
        res.slot = r.slot;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  function automatic tile_req_t build_req(func_e f, logic [KEY_W-1:0] key,
                                          coord_t cx, coord_t cy, coord_t cz,
                                          coord_t vx, coord_t vy, coord_t vz,
                                          logic [SLOT_W-1:0] s);
    tile_req_t r;
    r.func = f;
    {r.lon, r.lat, r.tx, r.ty} = key;
    r.cx = cx;
    r.cy = cy;
    r.cz = cz;
    r.vx = vx;
    r.vy = vy;
    r.vz = vz;
    r.slot = s;
    r.idle_pct = 0;
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic signed [8:0] lon;
    logic signed [7:0] lat;
    if ($urandom_range(0, 1) == 0) return KEY_W'($urandom);
    // A narrow key space so that inserts collide with earlier keys.
    lon = 9'($urandom_range(0, 4)) - 9'sd2;
    lat = 8'($urandom_range(0, 4)) - 8'sd2;
    return {lon, lat, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return COORD_BITS'($urandom);
      1: return ($urandom_range(0, 1) == 1) ? COORD_MAX : COORD_MIN;
      2, 3: return COORD_BITS'($urandom_range(0, 100)) - COORD_BITS'(50);
      default: return COORD_BITS'($urandom_range(0, 200000)) - COORD_BITS'(100000);
    endcase
  endfunction

  // Driver: holds a request on the pins until it is taken, then loads the next.
  always @(negedge clk_i) begin
    logic      launch;
    tile_req_t nxt;
    launch = start;
    if (start && accepted_reqs == launched_reqs) launch = 1'b0;
    if (rst_ni && !launch && pending_reqs.size() != 0) begin
      nxt = pending_reqs[0];
      if (!(nxt.drain_first && expected_results.size() != 0) &&
          $urandom_range(0, 99) >= nxt.idle_pct) begin
        cur_req = nxt;
        pending_reqs.delete(0);
        launched_reqs++;
        launch = 1'b1;
      end
    end
    start <= launch;
  end

  // Monitor: predicts on each accepted request and checks each result strobe.
  always @(posedge clk_i) begin
    tile_result_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        expected_results.push_back(apply_tile_request(cur_req));
        accepted_reqs++;
      end
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", slot_o, 0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (hit_o !== want.hit) report_mismatch("hit", hit_o, want.hit);
          if (slot_o !== want.slot) report_mismatch("slot", slot_o, want.slot);
          if (evicted_o !== want.evicted) report_mismatch("evicted", evicted_o, want.evicted);
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] dkeys [SLOTS];
    logic [KEY_W-1:0] key_pool[$];
    logic [KEY_W-1:0] key;
    tile_req_t        r;
    int unsigned      pick;
    int unsigned      phase_idle [4];

    phase_idle = '{0, 53, 0, 37};

    // Directed keys: field extremes, a duplicate of slot 1 in slot 3.
    dkeys[0] = {-9'sd180, -8'sd90, 3'd0, 3'd0};
    dkeys[1] = {9'sd179, 8'sd89, 3'd7, 3'd7};
    dkeys[2] = '0;
    dkeys[3] = dkeys[1];
    dkeys[4] = {9'h100, 8'h80, 3'd7, 3'd0};
    dkeys[5] = {9'h0FF, 8'h7F, 3'd0, 3'd7};
    for (int i = 6; i < SLOTS; i++) begin
      dkeys[i] = {9'(i), 8'(-i), 3'(i), 3'(~i)};
    end

    // Lookup on an empty table misses; a no-op still gives a result.
    pending_reqs.push_back(build_req(FUNC_LOOKUP, dkeys[1], '0, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(FUNC_NOP, '1, '1, '1, '1, '1, '1, '1, '1));
    // Fill every slot with centres at the origin.
    for (int i = 0; i < SLOTS; i++) begin
      pending_reqs.push_back(build_req(FUNC_INSERT, dkeys[i], '0, '0, '0, '0, '0, '0, '0));
    end
    // Duplicate key: the lowest matching slot answers.
    pending_reqs.push_back(build_req(FUNC_LOOKUP, dkeys[1], '0, '0, '0, '0, '0, '0, '0));
    // All distances zero: slot 0 is replaced.
    pending_reqs.push_back(build_req(FUNC_INSERT, 23'h2A5A5A, COORD_MAX, COORD_MIN, COORD_MAX,
                                     '0, '0, '0, '0));
    // View on slot 0: slots 1 to 15 tie and the first of them is replaced.
    pending_reqs.push_back(build_req(FUNC_INSERT, 23'h15A5A5, COORD_MIN, COORD_MAX, COORD_MIN,
                                     COORD_MAX, COORD_MIN, COORD_MAX, '0));
    pending_reqs.push_back(build_req(FUNC_LOOKUP, dkeys[1], '0, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(FUNC_FREE, '0, '0, '0, '0, '0, '0, '0, 4'd15));
    pending_reqs.push_back(build_req(FUNC_FREE, '0, '0, '0, '0, '0, '0, '0, 4'd0));
    // A freed entry no longer matches, and the next insert reuses it.
    pending_reqs.push_back(build_req(FUNC_LOOKUP, 23'h2A5A5A, '0, '0, '0, '0, '0, '0, '0));
    pending_reqs.push_back(build_req(FUNC_INSERT, 23'h7FFFFF, '0, '0, '0,
                                     COORD_MIN, COORD_MAX, COORD_MIN, '1));

    // Random traffic: inserts outnumber frees so the table stays mostly full.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (key_pool.size() != 0 && $urandom_range(0, 3) != 0) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        key = rand_key();
      end
      r = build_req(FUNC_NOP, key, rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), 4'($urandom_range(0, 15)));
      if (pick < 40) begin
        r.func = FUNC_LOOKUP;
      end else if (pick < 77) begin
        r.func = FUNC_INSERT;
        key_pool.push_back(key);
        if (key_pool.size() > 24) key_pool.delete(0);
      end else if (pick < 92) begin
        r.func = FUNC_FREE;
      end
      r.idle_pct = phase_idle[(n / PHASE_LEN) % 4];
      r.drain_first = (n % PHASE_LEN == 0) || ($urandom_range(0, 99) == 0);
      pending_reqs.push_back(r);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || accepted_reqs != launched_reqs) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * SLOTS + 8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
